[hdl/rcws_pkg.sv]
// Shared types and constants for the raycast wall column span unit.
// Used by every module of the block; depends on nothing else.
package rcws_pkg;

   // Default screen size, used as the defaults of the top level parameters.
   localparam int SCREEN_HEIGHT_DEF = 480;
   localparam int SCREEN_WIDTH_DEF  = 640;

   // Field widths.
   localparam int COL_W      = 10;
   localparam int CELL_W     = 6;
   localparam int POS_W      = 22;
   localparam int STEP_W     = 2;
   localparam int DIR_W      = 16;
   localparam int DIR_MAG_W  = 17;
   localparam int DEN_W      = 24;
   localparam int DEN_MAG_W  = 23;
   localparam int COLOR_W    = 24;
   localparam int HEIGHT_W   = 11;
   localparam int ROW_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 64;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACE_EAST  = 2'd0,
      CSR_FACE_WEST  = 2'd1,
      CSR_FACE_NORTH = 2'd2,
      CSR_FACE_SOUTH = 2'd3
   } csr_index_type;

   localparam logic [COLOR_W-1:0] FACE_EAST_RST  = 24'hFFB6C1;
   localparam logic [COLOR_W-1:0] FACE_WEST_RST  = 24'hE6E6FA;
   localparam logic [COLOR_W-1:0] FACE_NORTH_RST = 24'hADD8E6;
   localparam logic [COLOR_W-1:0] FACE_SOUTH_RST = 24'h90EE90;

   // Queue between the classifying front and the divider back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Fields that ride along with a column untouched by the divider.
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               on_screen;
      logic [COL_W-1:0]   col;
   } rcws_meta_type;

   // One classified column: magnitudes of the division operands and a
   // flag that forces the saturated height.
   typedef struct packed {
      rcws_meta_type        meta;
      logic                 sat;
      logic [DIR_MAG_W-1:0] dir_mag;
      logic [DEN_MAG_W-1:0] den_mag;
   } rcws_job_type;

endpackage

[hdl/raycast_wall_column_span_unit.sv]
// Raycast wall column span unit: for each ray hit it returns the projected
// wall height, the clamped first and last screen row, the face color and an
// on-screen flag. One column is taken every clock while the result side keeps
// up. The height comes from a pipelined divider that resolves one quotient
// bit per divider stage. A four-entry queue sits between the classifying
// front end and the divider, so the input keeps flowing while the result side
// stalls, until the queue is full. The height saturates at 4*SCREEN_HEIGHT;
// all fields are produced also for columns off screen. Face color registers
// are to be written by the user through the csr port only while idle; the
// block itself does not enforce this.
// Depends on rcws_pkg, rcws_front, rcws_queue and rcws_back.
module raycast_wall_column_span_unit #(
   parameter int SCREEN_HEIGHT = rcws_pkg::SCREEN_HEIGHT_DEF,
   parameter int SCREEN_WIDTH  = rcws_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rcws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcws_pkg::COLOR_W-1:0]    csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // screen_column, cell_x, cell_y, viewer_x, viewer_y, step_dir_x,
   // step_dir_y, dir_x, dir_y, two zero bits
   input  logic [rcws_pkg::REQ_DATA_W-1:0] req_tdata,
   // hit_side
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_column, slice_height, first_row, last_row, slice_color, one zero bit
   output logic [rcws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // column_on_screen
   output logic                            rsp_tuser
);

   rcws_pkg::rcws_job_type front_job;
   rcws_pkg::rcws_job_type queue_job;
   logic                   queue_valid;
   logic                   back_ready;

   rcws_front #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .job       (front_job)
   );

   rcws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_data   (queue_job)
   );

   rcws_back #(
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_valid),
      .job_ready  (back_ready),
      .job        (queue_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hdl/rcws_front.sv]
// Front end: holds the face color registers and classifies each ray hit.
// Selects the x or y fields, forms the distance term and the operand signs.
// Depends on rcws_pkg.
module rcws_front #(
   parameter int SCREEN_WIDTH = rcws_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rcws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcws_pkg::COLOR_W-1:0]       csr_wdata,
   input  logic [rcws_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   output rcws_pkg::rcws_job_type             job
);

   logic [rcws_pkg::COLOR_W-1:0] east_ff, east_in;
   logic [rcws_pkg::COLOR_W-1:0] west_ff, west_in;
   logic [rcws_pkg::COLOR_W-1:0] north_ff, north_in;
   logic [rcws_pkg::COLOR_W-1:0] south_ff, south_in;

   logic [rcws_pkg::COL_W-1:0]   col;
   logic [rcws_pkg::CELL_W-1:0]  hit_cell;
   logic [rcws_pkg::POS_W-1:0]   viewer;
   logic [rcws_pkg::STEP_W-1:0]  step;
   logic [rcws_pkg::STEP_W-1:0]  step_ofs;
   logic [rcws_pkg::DIR_W-1:0]   dir;
   logic [rcws_pkg::DIR_MAG_W-1:0] dir_ext;
   logic [rcws_pkg::DEN_W-1:0]   den;
   logic [rcws_pkg::DEN_W-1:0]   den_abs;
   logic                         den_neg;
   logic                         dir_neg;

   always_comb begin
      east_in  = east_ff;
      west_in  = west_ff;
      north_in = north_ff;
      south_in = south_ff;
      if (csr_we) begin
         case (rcws_pkg::csr_index_type'(csr_index))
            rcws_pkg::CSR_FACE_EAST:  east_in  = csr_wdata;
            rcws_pkg::CSR_FACE_WEST:  west_in  = csr_wdata;
            rcws_pkg::CSR_FACE_NORTH: north_in = csr_wdata;
            rcws_pkg::CSR_FACE_SOUTH: south_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         east_ff  <= rcws_pkg::FACE_EAST_RST;
         west_ff  <= rcws_pkg::FACE_WEST_RST;
         north_ff <= rcws_pkg::FACE_NORTH_RST;
         south_ff <= rcws_pkg::FACE_SOUTH_RST;
      end else begin
         east_ff  <= east_in;
         west_ff  <= west_in;
         north_ff <= north_in;
         south_ff <= south_in;
      end
   end

   always_comb begin
      col = req_tdata[9:0];
      if (req_tuser) begin
         hit_cell = req_tdata[21:16];
         viewer   = req_tdata[65:44];
         step     = req_tdata[69:68];
         dir      = req_tdata[101:86];
      end else begin
         hit_cell = req_tdata[15:10];
         viewer   = req_tdata[43:22];
         step     = req_tdata[67:66];
         dir      = req_tdata[85:70];
      end

      // (1 - step) taken modulo four gives 0..3 half cells for steps +1..-2.
      step_ofs = 2'd1 - step;
      den      = {2'b00, hit_cell, 16'd0} - {2'b00, viewer} + {7'd0, step_ofs, 15'd0};
      den_neg  = den[rcws_pkg::DEN_W-1];
      den_abs  = den_neg ? (24'd0 - den) : den;

      dir_neg  = dir[rcws_pkg::DIR_W-1];
      dir_ext  = {dir[rcws_pkg::DIR_W-1], dir};

      job.den_mag = den_abs[rcws_pkg::DEN_MAG_W-1:0];
      job.dir_mag = dir_neg ? (17'd0 - dir_ext) : dir_ext;
      // A zero distance or one that points behind the viewer saturates.
      job.sat     = (den == '0) || ((dir != '0) && (dir_neg != den_neg));

      job.meta.col       = col;
      job.meta.on_screen = ({1'b0, col} < 11'(SCREEN_WIDTH));
      if (req_tuser) begin
         job.meta.color = dir_neg ? north_ff : south_ff;
      end else begin
         job.meta.color = dir_neg ? east_ff : west_ff;
      end
   end

endmodule

[hdl/rcws_queue.sv]
// Short register based queue of classified columns between front and back end;
// one in per clock while not full, one out while not empty. Depends on rcws_pkg.
module rcws_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  rcws_pkg::rcws_job_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output rcws_pkg::rcws_job_type pop_data
);

   rcws_pkg::rcws_job_type mem_ff [rcws_pkg::QUEUE_DEPTH];
   rcws_pkg::rcws_job_type mem_in [rcws_pkg::QUEUE_DEPTH];
   logic [rcws_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rcws_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rcws_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign push_ready = (count_ff != rcws_pkg::QCNT_W'(rcws_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      mem_in = mem_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = push_data;
      end
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + rcws_pkg::QCNT_W'(push) - rcws_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/rcws_back.sv]
// Back end: pipelined restoring divider for the wall height, then row clamp.
// One quotient bit per divider stage; a result register follows the last stage.
// Depends on rcws_pkg.
module rcws_back #(
   parameter int SCREEN_HEIGHT = rcws_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   output logic                            job_ready,
   input  rcws_pkg::rcws_job_type          job,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rcws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int SAT      = 4 * SCREEN_HEIGHT;
   localparam int QW       = $clog2(SAT + 1);
   localparam int NUM_W    = QW + 15;
   localparam int PROD_W   = rcws_pkg::DIR_MAG_W + QW;
   localparam int CMP_W    = rcws_pkg::DEN_MAG_W + QW;
   localparam int XW       = (QW > rcws_pkg::HEIGHT_W) ? QW : rcws_pkg::HEIGHT_W;
   localparam int HALF     = SCREEN_HEIGHT / 2;
   localparam int LAST_MAX = SCREEN_HEIGHT - 1;
   localparam logic [QW-1:0] SAT_Q  = QW'(SAT);
   localparam logic [QW-1:0] HALF_Q = QW'(HALF);
   localparam logic [QW-1:0] LAST_Q = QW'(LAST_MAX);

   logic adv;

   // Multiply stage.
   logic [PROD_W-1:0]              prod;
   logic                           s0_valid_ff, s0_valid_in;
   logic [NUM_W-1:0]               s0_num_ff, s0_num_in;
   logic [rcws_pkg::DEN_MAG_W-1:0] s0_den_ff, s0_den_in;
   logic                           s0_sat_ff, s0_sat_in;
   rcws_pkg::rcws_meta_type        s0_meta_ff, s0_meta_in;

   // Divider stages: index 0 holds the overflow check, index k holds k bits.
   logic                           dvalid_ff [0:QW];
   logic                           dvalid_in [0:QW];
   logic [NUM_W-1:0]               drem_ff   [0:QW];
   logic [NUM_W-1:0]               drem_in   [0:QW];
   logic [QW-1:0]                  dquo_ff   [0:QW];
   logic [QW-1:0]                  dquo_in   [0:QW];
   logic [rcws_pkg::DEN_MAG_W-1:0] dden_ff   [0:QW];
   logic [rcws_pkg::DEN_MAG_W-1:0] dden_in   [0:QW];
   logic                           dsat_ff   [0:QW];
   logic                           dsat_in   [0:QW];
   rcws_pkg::rcws_meta_type        dmeta_ff  [0:QW];
   rcws_pkg::rcws_meta_type        dmeta_in  [0:QW];

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rcws_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic [QW-1:0] hq;
   logic [QW-1:0] half;
   logic [QW-1:0] first_q;
   logic [QW-1:0] last_sum;
   logic [QW-1:0] last_q;
   logic [XW-1:0] hx;
   logic [XW-1:0] first_x;
   logic [XW-1:0] last_x;

   // The whole pipe moves together whenever the result register can load.
   assign adv       = !rsp_valid_ff || rsp_tready;
   assign job_ready = adv;

   always_comb begin
      prod        = PROD_W'(job.dir_mag) * PROD_W'(SAT);
      s0_valid_in = adv ? job_valid : s0_valid_ff;
      s0_num_in   = adv ? prod[NUM_W-1:0] : s0_num_ff;
      s0_den_in   = adv ? job.den_mag : s0_den_ff;
      s0_sat_in   = adv ? job.sat : s0_sat_ff;
      s0_meta_in  = adv ? job.meta : s0_meta_ff;
   end

   always_ff @(posedge clock) begin
      s0_num_ff  <= s0_num_in;
      s0_den_ff  <= s0_den_in;
      s0_sat_ff  <= s0_sat_in;
      s0_meta_ff <= s0_meta_in;
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   // A quotient at or above 2**QW is already past the saturation height.
   always_comb begin
      if (adv) begin
         dvalid_in[0] = s0_valid_ff;
         drem_in[0]   = s0_num_ff;
         dquo_in[0]   = '0;
         dden_in[0]   = s0_den_ff;
         dsat_in[0]   = s0_sat_ff ||
                        (CMP_W'(s0_num_ff) >= {s0_den_ff, {QW{1'b0}}});
         dmeta_in[0]  = s0_meta_ff;
      end else begin
         dvalid_in[0] = dvalid_ff[0];
         drem_in[0]   = drem_ff[0];
         dquo_in[0]   = dquo_ff[0];
         dden_in[0]   = dden_ff[0];
         dsat_in[0]   = dsat_ff[0];
         dmeta_in[0]  = dmeta_ff[0];
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      localparam int BIT = QW - k;
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] diff;
      logic [QW-1:0]    quo_set;
      logic             ge;

      always_comb begin
         shifted = CMP_W'(dden_ff[k-1]) << BIT;
         ge      = (CMP_W'(drem_ff[k-1]) >= shifted);
         diff    = CMP_W'(drem_ff[k-1]) - shifted;
         quo_set = dquo_ff[k-1];
         quo_set[BIT] = ge;
         if (adv) begin
            dvalid_in[k] = dvalid_ff[k-1];
            drem_in[k]   = ge ? diff[NUM_W-1:0] : drem_ff[k-1];
            dquo_in[k]   = quo_set;
            dden_in[k]   = dden_ff[k-1];
            dsat_in[k]   = dsat_ff[k-1];
            dmeta_in[k]  = dmeta_ff[k-1];
         end else begin
            dvalid_in[k] = dvalid_ff[k];
            drem_in[k]   = drem_ff[k];
            dquo_in[k]   = dquo_ff[k];
            dden_in[k]   = dden_ff[k];
            dsat_in[k]   = dsat_ff[k];
            dmeta_in[k]  = dmeta_ff[k];
         end
      end
   end

   for (genvar k = 0; k <= QW; k++) begin : g_stage
      always_ff @(posedge clock) begin
         drem_ff[k]  <= drem_in[k];
         dquo_ff[k]  <= dquo_in[k];
         dden_ff[k]  <= dden_in[k];
         dsat_ff[k]  <= dsat_in[k];
         dmeta_ff[k] <= dmeta_in[k];
         if (reset) begin
            dvalid_ff[k] <= 1'b0;
         end else begin
            dvalid_ff[k] <= dvalid_in[k];
         end
      end
   end

   // Height, then a span centered on the middle row and clamped to the screen.
   always_comb begin
      hq       = (dsat_ff[QW] || (dquo_ff[QW] > SAT_Q)) ? SAT_Q : dquo_ff[QW];
      half     = hq >> 1;
      first_q  = (half > HALF_Q) ? '0 : (HALF_Q - half);
      last_sum = HALF_Q + half;
      last_q   = (last_sum > LAST_Q) ? LAST_Q : last_sum;
      hx       = XW'(hq);
      first_x  = XW'(first_q);
      last_x   = XW'(last_q);

      rsp_valid_in = adv ? dvalid_ff[QW] : rsp_valid_ff;
      rsp_user_in  = adv ? dmeta_ff[QW].on_screen : rsp_user_ff;
      rsp_data_in  = adv ? {1'b0,
                            dmeta_ff[QW].color,
                            last_x[rcws_pkg::ROW_W-1:0],
                            first_x[rcws_pkg::ROW_W-1:0],
                            hx[rcws_pkg::HEIGHT_W-1:0],
                            dmeta_ff[QW].col}
                         : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
